@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_NR(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/crd_pkg.sv @@
// shared widths, defaults and types for the coordinate rms deviation unit
package crd_pkg;

  localparam int FIELD_W        = 20;     // coordinate port width
  localparam int SUM_W          = 60;     // running sum of squares
  localparam int CNT_W          = 17;     // atom count
  localparam int RMS_W          = 21;     // result width
  localparam int ROOT_W         = SUM_W / 2;
  localparam int AXES           = 3;
  localparam int QDEPTH         = 2;      // sets waiting between front and back
  localparam int MAX_ATOMS_DEF  = 65536;
  localparam int COORD_BITS_DEF = 20;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } crd_set_t;

endpackage

@@ rtl/crd_front.sv @@
// front part: squared differences pipeline and per-set accumulator
module crd_front import crd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_ATOMS  = MAX_ATOMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               stall,
  input  logic [FIELD_W-1:0] src [AXES],
  input  logic [FIELD_W-1:0] tgt [AXES],
  input  logic               last_in,
  output logic               q_push,
  output crd_set_t           q_data,
  input  logic               q_full
);

  localparam int DW   = COORD_BITS + 1;
  localparam int SQ_W = 2 * DW;
  localparam int SS_W = SQ_W + 2;

  logic [DW-1:0]   sc [AXES];
  logic [DW-1:0]   tc [AXES];
  logic [DW-1:0]   dif [AXES];
  logic [DW-1:0]   ad_next [AXES];

  // stage 1: absolute differences
  logic            v1, last1;
  logic [DW-1:0]   ad [AXES];
  // stage 2: squares
  logic            v2, last2;
  logic [SQ_W-1:0] sq [AXES];
  // stage 3: per-atom sum
  logic            v3, last3;
  logic [SS_W-1:0] ssum;

  // accumulator
  logic [SUM_W-1:0] squared_sum, sum_next;
  logic [CNT_W-1:0] atom_count, count_next;
  logic             overflow_seen, ovf_next;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sc[i]  = {src[i][COORD_BITS-1], src[i][COORD_BITS-1:0]};
      tc[i]  = {tgt[i][COORD_BITS-1], tgt[i][COORD_BITS-1:0]};
      dif[i] = sc[i] - tc[i];
      ad_next[i] = dif[i][DW-1] ? DW'(-dif[i]) : dif[i];
    end
  end

  assign stall = v3 && last3 && q_full;

  always_comb begin
    if (atom_count < CNT_W'(MAX_ATOMS)) begin
      sum_next   = squared_sum + SUM_W'(ssum);
      count_next = atom_count + CNT_W'(1);
      ovf_next   = overflow_seen;
    end else begin
      sum_next   = squared_sum;
      count_next = atom_count;
      ovf_next   = 1'b1;
    end
  end

  assign q_push       = v3 && last3 && !q_full;
  assign q_data.sum   = sum_next;
  assign q_data.count = count_next;
  assign q_data.ovf   = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      squared_sum   <= '0;
      atom_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (!stall) begin
      v1    <= in_valid;
      last1 <= last_in;
      ad    <= ad_next;
      v2    <= v1;
      last2 <= last1;
      for (int i = 0; i < AXES; i++) begin
        sq[i] <= SQ_W'(ad[i] * ad[i]);
      end
      v3    <= v2;
      last3 <= last2;
      ssum  <= SS_W'(sq[0]) + SS_W'(sq[1]) + SS_W'(sq[2]);
      if (v3) begin
        if (last3) begin
          squared_sum   <= '0;
          atom_count    <= '0;
          overflow_seen <= 1'b0;
        end else begin
          squared_sum   <= sum_next;
          atom_count    <= count_next;
          overflow_seen <= ovf_next;
        end
      end
    end
  end

endmodule

@@ rtl/crd_queue.sv @@
// short queue of finished sets between the front and back parts
module crd_queue import crd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  crd_set_t wdata,
  output logic     full,
  input  logic     pop,
  output crd_set_t rdata,
  output logic     empty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FILL_W = $clog2(QDEPTH + 1);

  crd_set_t            slots [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [FILL_W-1:0]   fill;
  logic                do_push, do_pop;

  assign full    = (fill == FILL_W'(QDEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= wdata;
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

@@ rtl/crd_back.sv @@
// back part: serial divide, serial square root and result register
module crd_back import crd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  crd_set_t         q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [RMS_W-1:0] rms_value,
  output logic [CNT_W-1:0] atom_total,
  output logic             count_overflow
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam int SR_W   = ROOT_W + 3;

  typedef enum logic [1:0] {IDLE, DIV, ROOT, HOLD} state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  work;      // dividend, then quotient, then radicand
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W-1:0]  rem;
  logic              ovf;
  logic [ROOT_W-1:0] root;
  logic [SR_W-1:0]   sq_rem;
  logic              out_valid;
  logic              load_result;

  logic [CNT_W:0]    div_shift;
  logic              div_ge;
  logic [CNT_W:0]    div_sub;
  logic [SR_W-1:0]   sr_shift;
  logic [SR_W-1:0]   sr_trial;
  logic              sr_ge;

  always_comb begin
    div_shift = {rem, work[SUM_W-1]};
    div_ge    = div_shift >= {1'b0, divisor};
    div_sub   = div_shift - {1'b0, divisor};
    sr_shift  = {sq_rem[SR_W-3:0], work[SUM_W-1:SUM_W-2]};
    sr_trial  = SR_W'({root, 2'b01});
    sr_ge     = sr_shift >= sr_trial;
  end

  assign q_pop       = (state == IDLE) && !q_empty;
  assign empty       = !out_valid;
  // result slot is free, or its transaction leaves this cycle
  assign load_result = (state == HOLD) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            work    <= q_data.sum;
            divisor <= q_data.count;
            ovf     <= q_data.ovf;
            rem     <= '0;
            step    <= '0;
            state   <= DIV;
          end
        end
        DIV: begin
          // one quotient bit a cycle, quotient shifts into the low end
          rem  <= div_ge ? div_sub[CNT_W-1:0] : div_shift[CNT_W-1:0];
          work <= {work[SUM_W-2:0], div_ge};
          if (step == STEP_W'(SUM_W - 1)) begin
            step   <= '0;
            root   <= '0;
            sq_rem <= '0;
            state  <= ROOT;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ROOT: begin
          // one root bit a cycle from two radicand bits
          sq_rem <= sr_ge ? sr_shift - sr_trial : sr_shift;
          root   <= {root[ROOT_W-2:0], sr_ge};
          work   <= {work[SUM_W-3:0], 2'b00};
          if (step == STEP_W'(ROOT_W - 1)) begin
            state <= HOLD;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        HOLD: begin
          if (load_result) begin
            rms_value      <= root[RMS_W-1:0];
            atom_total     <= divisor;
            count_overflow <= ovf;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ rtl/coordinate_rms_deviation_unit.sv @@
// top level of the coordinate rms deviation unit
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  atoms    | push / full           | source_x..z, target_x..z, last_atom
//  results  | pop / empty           | rms_value, atom_total, count_overflow
//
// an atom is taken every cycle while full is low; full rises only when a set's
// last atom leaves the square pipeline and the set queue is full
// a set's last atom passes the 3 pipeline stages; its totals then go through the
// set queue, the serial divide and the serial square root in the back part
// the back part takes the next set only after the last result enters the slot
// reset (rst, synchronous) clears the accumulator, the queue and the result slot
module coordinate_rms_deviation_unit import crd_pkg::*; #(
  parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [FIELD_W-1:0] source_x,
  input  logic [FIELD_W-1:0] source_y,
  input  logic [FIELD_W-1:0] source_z,
  input  logic [FIELD_W-1:0] target_x,
  input  logic [FIELD_W-1:0] target_y,
  input  logic [FIELD_W-1:0] target_z,
  input  logic               last_atom,
  output logic               empty,
  input  logic               pop,
  output logic [RMS_W-1:0]   rms_value,
  output logic [CNT_W-1:0]   atom_total,
  output logic               count_overflow
);

  // coordinates grouped per axis for the front part
  logic [FIELD_W-1:0] src [AXES];
  logic [FIELD_W-1:0] tgt [AXES];

  // front to queue
  logic     f_push;
  crd_set_t f_data;
  logic     q_full;

  // queue to back
  logic     q_pop;
  crd_set_t q_data;
  logic     q_empty;

  assign src[0] = source_x;
  assign src[1] = source_y;
  assign src[2] = source_z;
  assign tgt[0] = target_x;
  assign tgt[1] = target_y;
  assign tgt[2] = target_z;

  // front: absolute differences, squares, per-atom sum, running sum and count;
  // a set's last atom pushes the finished totals into the queue
  crd_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_ATOMS  (MAX_ATOMS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push),
    .stall    (full),
    .src      (src),
    .tgt      (tgt),
    .last_in  (last_atom),
    .q_push   (f_push),
    .q_data   (f_data),
    .q_full   (q_full)
  );

  // finished sets wait here while the back part is busy
  crd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_data),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  // back: mean by serial divide, floor root, then the result slot
  crd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .rms_value      (rms_value),
    .atom_total     (atom_total),
    .count_overflow (count_overflow)
  );

endmodule

@@ rtl/crd_checker.sv @@
// port checker for the coordinate rms deviation unit, with its bind
`include "assert_macros.svh"

module crd_port_checker import crd_pkg::*; #(
  parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input logic [RMS_W-1:0] rms_value,
  input logic [CNT_W-1:0] atom_total,
  input logic             count_overflow
);

  logic [RMS_W+CNT_W:0] result_bus;

  assign result_bus = {rms_value, atom_total, count_overflow};

  `ASSERT_NEXT_NR(a_reset_empty, clk, rst, empty)
  `ASSERT_NEXT(a_hold_result, clk, rst, !empty && !pop, !empty && $stable(result_bus))
  `ASSERT_IMPL(a_total_range, clk, rst, !empty, atom_total != '0 && atom_total <= CNT_W'(MAX_ATOMS))
  `ASSERT_IMPL(a_ovf_full, clk, rst, !empty && count_overflow, atom_total == CNT_W'(MAX_ATOMS))

endmodule

bind coordinate_rms_deviation_unit crd_port_checker #(
  .MAX_ATOMS (MAX_ATOMS)
) u_crd_checker (
  .clk            (clk),
  .rst            (rst),
  .empty          (empty),
  .pop            (pop),
  .rms_value      (rms_value),
  .atom_total     (atom_total),
  .count_overflow (count_overflow)
);
